// ===== sv/mhpq_pkg.sv =====
// Shared types and codes for the max-heap priority queue.
package mhpq_pkg;

    localparam int KEY_W = 32;
    localparam int PAY_W = 32;

    // One heap slot: signed key and opaque payload word
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [PAY_W-1:0]        payload;
    } entry_t;

    // Command codes
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    // Result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_CHK,
        ST_INS_CMP,
        ST_RM_ROOT,
        ST_RM_LAST,
        ST_DN_CHK,
        ST_DN_L,
        ST_DN_R
    } state_t;

endpackage

// ===== sv/max_heap_priority_queue.sv =====
// Binary max-heap priority queue held in one synchronous slot memory.
// Full insert or empty remove is answered from idle; insert sifts up, reading and comparing
//   the parent per level; remove reads the root, then the last entry, and sifts down,
//   reading the left child, then the right when both exist. Left and right child reads
//   share the single read port. Start is taken only while busy is low, and done pulses
//   one cycle. Reset clears the entry count, the sequencer and the done strobe only.
module max_heap_priority_queue
    import mhpq_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    cmd,
    input  logic signed [KEY_W-1:0] key,
    input  logic [PAY_W-1:0]        payload,
    output logic                    done,
    output logic [1:0]              status,
    output logic signed [KEY_W-1:0] out_key,
    output logic [PAY_W-1:0]        out_payload,
    output logic [6:0]              count
);

    localparam int IW = $clog2(CAPACITY + 1);
    localparam logic [IW-1:0] CAP_IDX  = IW'(CAPACITY);
    localparam logic [IW-1:0] ROOT_IDX = IW'(1);

    // Slot memory, slots 1 to CAPACITY
    entry_t mem [0:CAPACITY];

    logic           rd_en;
    logic [IW-1:0]  rd_addr;
    entry_t         rd_data_reg;
    logic           wr_en;
    logic [IW-1:0]  wr_addr;
    entry_t         wr_data;

    state_t         state_reg, state_next;
    logic [IW-1:0]  cnt_reg, cnt_next;
    logic [IW-1:0]  pos_reg, pos_next;
    logic [IW:0]    child_reg, child_next;
    entry_t         move_reg, move_next;
    entry_t         best_reg, best_next;
    logic           done_reg, done_next;
    logic [1:0]     status_reg, status_next;
    entry_t         res_reg, res_next;
    logic [6:0]     count_reg, count_next;

    entry_t         cand;
    logic [IW-1:0]  cand_idx;
    logic           take_right;

    // Memory ports
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        pos_reg    <= pos_next;
        child_reg  <= child_next;
        move_reg   <= move_next;
        best_reg   <= best_next;
        status_reg <= status_next;
        res_reg    <= res_next;
        count_reg  <= count_next;
    end

    // Larger child: right only when strictly larger than left
    always_comb
    begin
        take_right = (state_reg == ST_DN_R) && ($signed(rd_data_reg.key) > $signed(best_reg.key));
        if (state_reg == ST_DN_R && !take_right)
        begin
            cand     = best_reg;
            cand_idx = child_reg[IW-1:0];
        end
        else if (state_reg == ST_DN_R)
        begin
            cand     = rd_data_reg;
            cand_idx = child_reg[IW-1:0] + ROOT_IDX;
        end
        else
        begin
            cand     = rd_data_reg;
            cand_idx = child_reg[IW-1:0];
        end
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        pos_next    = pos_reg;
        child_next  = child_reg;
        move_next   = move_reg;
        best_next   = best_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        res_next    = res_reg;
        count_next  = count_reg;
        rd_en       = 1'b0;
        rd_addr     = pos_reg;
        wr_en       = 1'b0;
        wr_addr     = pos_reg;
        wr_data     = move_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    res_next = '0;
                    if (cmd == CMD_INSERT)
                    begin
                        if (cnt_reg >= CAP_IDX)
                        begin
                            done_next   = 1'b1;
                            status_next = STATUS_FULL;
                            count_next  = 7'(cnt_reg);
                        end
                        else
                        begin
                            cnt_next   = cnt_reg + ROOT_IDX;
                            pos_next   = cnt_reg + ROOT_IDX;
                            move_next  = '{key: key, payload: payload};
                            state_next = ST_INS_CHK;
                        end
                    end
                    else
                    begin
                        if (cnt_reg == '0)
                        begin
                            done_next   = 1'b1;
                            status_next = STATUS_EMPTY;
                            count_next  = '0;
                        end
                        else
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = ROOT_IDX;
                            state_next = ST_RM_ROOT;
                        end
                    end
                end
            end

            // Sift up: fetch parent unless at the root
            ST_INS_CHK:
            begin
                if (pos_reg == ROOT_IDX)
                begin
                    wr_en       = 1'b1;
                    done_next   = 1'b1;
                    status_next = STATUS_OK;
                    count_next  = 7'(cnt_reg);
                    state_next  = ST_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = pos_reg >> 1;
                    state_next = ST_INS_CMP;
                end
            end

            // Move parent down if strictly smaller, else settle here
            ST_INS_CMP:
            begin
                wr_en = 1'b1;
                if ($signed(move_reg.key) > $signed(rd_data_reg.key))
                begin
                    wr_data    = rd_data_reg;
                    pos_next   = pos_reg >> 1;
                    state_next = ST_INS_CHK;
                end
                else
                begin
                    done_next   = 1'b1;
                    status_next = STATUS_OK;
                    count_next  = 7'(cnt_reg);
                    state_next  = ST_IDLE;
                end
            end

            // Root is the result; fetch the last entry
            ST_RM_ROOT:
            begin
                res_next   = rd_data_reg;
                rd_en      = 1'b1;
                rd_addr    = cnt_reg;
                cnt_next   = cnt_reg - ROOT_IDX;
                state_next = ST_RM_LAST;
            end

            ST_RM_LAST:
            begin
                move_next  = rd_data_reg;
                pos_next   = ROOT_IDX;
                child_next = (IW + 1)'(2);
                state_next = ST_DN_CHK;
            end

            // Sift down: stop when no child remains
            ST_DN_CHK:
            begin
                if (child_reg > {1'b0, cnt_reg})
                begin
                    wr_en       = 1'b1;
                    done_next   = 1'b1;
                    status_next = STATUS_OK;
                    count_next  = 7'(cnt_reg);
                    state_next  = ST_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = child_reg[IW-1:0];
                    state_next = ST_DN_L;
                end
            end

            ST_DN_L, ST_DN_R:
            begin
                if (state_reg == ST_DN_L && child_reg < {1'b0, cnt_reg})
                begin
                    // Left child in hand, fetch right child
                    best_next  = rd_data_reg;
                    rd_en      = 1'b1;
                    rd_addr    = child_reg[IW-1:0] + ROOT_IDX;
                    state_next = ST_DN_R;
                end
                else if ($signed(move_reg.key) >= $signed(cand.key))
                begin
                    wr_en       = 1'b1;
                    done_next   = 1'b1;
                    status_next = STATUS_OK;
                    count_next  = 7'(cnt_reg);
                    state_next  = ST_IDLE;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_data    = cand;
                    pos_next   = cand_idx;
                    child_next = {cand_idx, 1'b0};
                    state_next = ST_DN_CHK;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign out_key     = res_reg.key;
    assign out_payload = res_reg.payload;
    assign count       = count_reg;

`ifndef SYNTHESIS
    // Results only appear once the sequencer is back at rest
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    // Entry count stays within capacity
    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= CAP_IDX)
        else $error("entry count above capacity");

    // Insert into a full heap is refused in the next cycle
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd == CMD_INSERT && cnt_reg == CAP_IDX)
        |=> (done && status == STATUS_FULL))
        else $error("full insert not refused");

    // Empty status always reports zero entries
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STATUS_EMPTY) |-> (count == 7'd0))
        else $error("empty status with nonzero count");

    // No read of a slot in the same cycle it is written
    a_rw: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("read and write collide on one slot");
`endif

endmodule
